// ===== rtl/core/ilt_pkg.sv =====
// ilt_pkg: shared types and constants of the chat-protocol line tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package ilt_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned PCNT_W  = 4;
   localparam int unsigned ERR_W   = 3;

   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

   localparam logic [PCNT_W-1:0] PARAM_LIMIT_RESET = 4'd15;
   localparam logic [PCNT_W-1:0] PCNT_MAX          = 4'd15;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_SEP   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PFX   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CMD   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PARAM = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TRAIL = 3'd4;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
   localparam logic [ERR_W-1:0] ERR_NUL  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_PFX  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_CMD  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_MANY = 3'd4;

   // register map
   localparam int unsigned PADDR_W = 3;
   localparam logic [PADDR_W-1:0] ADDR_PARAM_LIMIT = 3'd0;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      logic [KIND_W-1:0] token_kind;
      logic              token_start;
      logic              is_content;
      logic [PCNT_W-1:0] param_number;
      logic              line_done;
      logic              line_ok;
      logic [ERR_W-1:0]  error_code;
   } result_type;

endpackage

// ===== rtl/core/ilt_parser.sv =====
// ilt_parser: phase machine and per-byte tagging of one line.
// Depends on ilt_pkg. State advances only when advance is high.
`timescale 1ns / 1ps

module ilt_parser
   import ilt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [BYTE_W-1:0] line_byte,
   input  logic              last_byte,
   input  logic [PCNT_W-1:0] param_limit,
   output result_type        result
);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_PFX_MARK,
      PH_PFX,
      PH_AFTER_PFX,
      PH_CMD,
      PH_GAP,
      PH_PARAM,
      PH_TRAIL
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [PCNT_W-1:0] pcount_ff, pcount_in;
   logic [ERR_W-1:0]  err_ff, err_in;

   always_comb begin
      logic              sp;
      logic [ERR_W-1:0]  err;
      phase_type         ph;
      logic [PCNT_W-1:0] cnt;
      logic [PCNT_W-1:0] cur;

      sp  = (line_byte == CHAR_SPACE);
      err = err_ff;
      ph  = phase_ff;
      cnt = pcount_ff;
      cur = (pcount_ff != '0) ? pcount_ff - 1'b1 : '0;

      result              = '0;
      result.byte_out     = line_byte;
      result.token_kind   = KIND_SEP;
      result.line_done    = last_byte;

      if (line_byte == CHAR_NUL) begin
         err = ERR_NUL;
      end

      case (phase_ff)
         PH_LEAD: begin
            if (!sp) begin
               result.token_start = 1'b1;
               if (line_byte == CHAR_COLON) begin
                  result.token_kind = KIND_PFX;
                  ph = PH_PFX_MARK;
               end else begin
                  result.token_kind = KIND_CMD;
                  result.is_content = 1'b1;
                  ph = PH_CMD;
               end
            end
         end
         PH_PFX_MARK: begin
            if (sp) begin
               if (err == ERR_NONE) begin
                  err = ERR_PFX;
               end
               ph = PH_AFTER_PFX;
            end else begin
               result.token_kind = KIND_PFX;
               result.is_content = 1'b1;
               ph = PH_PFX;
            end
         end
         PH_PFX: begin
            if (sp) begin
               ph = PH_AFTER_PFX;
            end else begin
               result.token_kind = KIND_PFX;
               result.is_content = 1'b1;
            end
         end
         PH_AFTER_PFX: begin
            if (!sp) begin
               result.token_kind  = KIND_CMD;
               result.token_start = 1'b1;
               result.is_content  = 1'b1;
               ph = PH_CMD;
            end
         end
         PH_CMD: begin
            if (sp) begin
               ph = PH_GAP;
            end else begin
               result.token_kind = KIND_CMD;
               result.is_content = 1'b1;
            end
         end
         PH_GAP: begin
            if (!sp) begin
               if (pcount_ff >= param_limit && err == ERR_NONE) begin
                  err = ERR_MANY;
               end
               result.param_number = pcount_ff;
               result.token_start  = 1'b1;
               if (pcount_ff != PCNT_MAX) begin
                  cnt = pcount_ff + 1'b1;
               end
               if (line_byte == CHAR_COLON) begin
                  result.token_kind = KIND_TRAIL;
                  ph = PH_TRAIL;
               end else begin
                  result.token_kind = KIND_PARAM;
                  result.is_content = 1'b1;
                  ph = PH_PARAM;
               end
            end
         end
         PH_PARAM: begin
            if (sp) begin
               ph = PH_GAP;
            end else begin
               result.token_kind   = KIND_PARAM;
               result.is_content   = 1'b1;
               result.param_number = cur;
            end
         end
         PH_TRAIL: begin
            result.token_kind   = KIND_TRAIL;
            result.is_content   = 1'b1;
            result.param_number = cur;
         end
         default: begin
            ph = PH_LEAD;
         end
      endcase

      if (result.token_kind == KIND_CMD && line_byte inside {[8'h61:8'h7A]}) begin
         result.byte_out = line_byte - CASE_DELTA;
      end

      if (last_byte) begin
         if (ph == PH_PFX_MARK) begin
            if (err == ERR_NONE) begin
               err = ERR_PFX;
            end
         end else if (ph == PH_LEAD || ph == PH_PFX || ph == PH_AFTER_PFX) begin
            if (err == ERR_NONE) begin
               err = ERR_CMD;
            end
         end
         result.line_ok    = (err == ERR_NONE);
         result.error_code = err;
         ph  = PH_LEAD;
         cnt = '0;
         err = ERR_NONE;
      end

      phase_in  = ph;
      pcount_in = cnt;
      err_in    = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         pcount_ff <= '0;
         err_ff    <= ERR_NONE;
      end else if (advance) begin
         phase_ff  <= phase_in;
         pcount_ff <= pcount_in;
         err_ff    <= err_in;
      end
   end

endmodule

// ===== rtl/core/irc_line_tokenizer.sv =====
// irc_line_tokenizer: top level of the streaming chat-protocol line tokenizer.
// Depends on ilt_pkg and ilt_parser.
`timescale 1ns / 1ps

// How to use:
//  - req channel carries one byte of a command line per transfer, with
//    req_last_byte marking the final byte. A transfer happens at a clock
//    edge with req_valid high and req_stall low.
//  - rsp channel returns exactly one tagged result per byte, in order:
//    token kind, token start, content flag, parameter index, and on the
//    last byte the line status and the first error; a NUL always wins.
//  - Two register stages: an input register and a result register, with
//    the tagging logic and the phase machine between them. rsp_valid rises
//    as a byte enters the result register; one byte per cycle unstalled.
//  - The phase machine is the only loop: each byte's state update finishes
//    in the cycle it leaves the input register.
//  - When the receiver stalls, the result register holds and the input
//    register can still take one byte; req_stall rises only once both are
//    full and the receiver is still stalling.
//  - Reset (synchronous) empties both stages, returns the phase machine to
//    the start of a line and sets the parameter limit to 15.
//  - The parameter limit lives at byte address 0 of the APB port; write it
//    only while no line is in flight.

module irc_line_tokenizer
   import ilt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input byte stream
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_line_byte,
   input  logic               req_last_byte,
   // tagged result stream
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_byte_out,
   output logic [KIND_W-1:0]  rsp_token_kind,
   output logic               rsp_token_start,
   output logic               rsp_is_content,
   output logic [PCNT_W-1:0]  rsp_param_number,
   output logic               rsp_line_done,
   output logic               rsp_line_ok,
   output logic [ERR_W-1:0]   rsp_error_code,
   // configuration
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;
   logic              out_valid_ff;
   result_type        out_ff;
   result_type        res_in;
   logic [PCNT_W-1:0] param_limit_ff;
   logic              out_free;
   logic              s1_adv;
   logic              req_xfer;

   // result register frees up when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_line_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   ilt_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_adv),
      .line_byte   (s1_byte_ff),
      .last_byte   (s1_last_ff),
      .param_limit (param_limit_ff),
      .result      (res_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_ff <= res_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_out     = out_ff.byte_out;
   assign rsp_token_kind   = out_ff.token_kind;
   assign rsp_token_start  = out_ff.token_start;
   assign rsp_is_content   = out_ff.is_content;
   assign rsp_param_number = out_ff.param_number;
   assign rsp_line_done    = out_ff.line_done;
   assign rsp_line_ok      = out_ff.line_ok;
   assign rsp_error_code   = out_ff.error_code;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         param_limit_ff <= PARAM_LIMIT_RESET;
      end else if (psel && penable && pwrite && pready && paddr == ADDR_PARAM_LIMIT) begin
         param_limit_ff <= pwdata[PCNT_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_PARAM_LIMIT) ? {{(32-PCNT_W){1'b0}}, param_limit_ff} : '0;

   // status is only reported on the last byte
   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_done |-> rsp_error_code == ERR_NONE && !rsp_line_ok)
      else $error("line status outside last byte");

   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_line_ok == (rsp_error_code == ERR_NONE))
      else $error("line_ok disagrees with error_code");

   a_sep_is_bare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_SEP |-> !rsp_is_content && !rsp_token_start)
      else $error("separator tagged as token text");

   a_xfer_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted byte lost from input register");

endmodule

// ===== bench/irc_line_tokenizer_test.sv =====
// irc_line_tokenizer_test: self-checking bench for the chat-protocol line tokenizer.
// Drives byte streams plus parameter limit writes over APB, checks every tagged result.
// Depends on ilt_pkg and irc_line_tokenizer.
`timescale 1ns / 1ps

module irc_line_tokenizer_test;
   import ilt_pkg::*;

   localparam int unsigned IDLE_LIMIT = 4000;  // cycles with no transfer before giving up
   localparam int unsigned PHASE_BYTES = 215;  // random bytes per limit setting

   // phase of the line being tagged
   typedef enum logic [2:0] {
      ST_LEAD, ST_MARK, ST_PREFIX, ST_PREFIX_GAP,
      ST_COMMAND, ST_PARAM_GAP, ST_MIDDLE, ST_TRAILING
   } line_phase_type;

   typedef struct {
      logic [BYTE_W-1:0] b;
      logic              last;
      bit                typed;  // use the result typed into the row
      result_type        want;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_line_byte;
   logic               req_last_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [BYTE_W-1:0]  rsp_byte_out;
   logic [KIND_W-1:0]  rsp_token_kind;
   logic               rsp_token_start;
   logic               rsp_is_content;
   logic [PCNT_W-1:0]  rsp_param_number;
   logic               rsp_line_done;
   logic               rsp_line_ok;
   logic [ERR_W-1:0]   rsp_error_code;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   // predictor state, kept apart from the block
   line_phase_type     line_phase;
   logic [PCNT_W-1:0]  open_params;
   logic [ERR_W-1:0]   first_fault;
   logic [PCNT_W-1:0]  limit_params;

   result_type         expected_tags[$];
   stim_row_type       directed[$];
   int unsigned        fail_count;
   int unsigned        bytes_sent;
   int unsigned        idle_cycles;
   bit                 req_quiet;   // sender sends back to back
   bit                 rsp_quiet;   // receiver never stalls

   irc_line_tokenizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_line_byte    (req_line_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_is_content   (rsp_is_content),
      .rsp_param_number (rsp_param_number),
      .rsp_line_done    (rsp_line_done),
      .rsp_line_ok      (rsp_line_ok),
      .rsp_error_code   (rsp_error_code),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // A NUL always wins; any other code only lands on a clean line.
   function automatic void note_error(input logic [ERR_W-1:0] code);
      if (code == ERR_NUL)
         first_fault = ERR_NUL;
      else if (first_fault == ERR_NONE)
         first_fault = code;
   endfunction

   function automatic result_type make_tags(input logic [BYTE_W-1:0] b,
                                            input logic [KIND_W-1:0] kind,
                                            input logic start, input logic content,
                                            input logic [PCNT_W-1:0] pnum,
                                            input logic done, input logic ok,
                                            input logic [ERR_W-1:0] err);
      result_type r;
      r.byte_out     = b;
      r.token_kind   = kind;
      r.token_start  = start;
      r.is_content   = content;
      r.param_number = pnum;
      r.line_done    = done;
      r.line_ok      = ok;
      r.error_code   = err;
      return r;
   endfunction

   // Tags one byte and advances the line state; state clears on the last byte.
   function automatic result_type tag_byte(input logic [BYTE_W-1:0] b, input logic last);
      result_type r;
      logic       sp;
      r          = '0;
      r.byte_out = b;
      sp         = (b == CHAR_SPACE);
      if (b == CHAR_NUL)
         note_error(ERR_NUL);
      case (line_phase)
         ST_LEAD: begin
            if (!sp) begin
               r.token_start = 1'b1;
               if (b == CHAR_COLON) begin
                  r.token_kind = KIND_PFX;
                  line_phase   = ST_MARK;
               end else begin
                  r.token_kind = KIND_CMD;
                  r.is_content = 1'b1;
                  line_phase   = ST_COMMAND;
               end
            end
         end
         ST_MARK: begin
            if (sp) begin
               note_error(ERR_PFX);
               line_phase = ST_PREFIX_GAP;
            end else begin
               r.token_kind = KIND_PFX;
               r.is_content = 1'b1;
               line_phase   = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            if (sp) begin
               line_phase = ST_PREFIX_GAP;
            end else begin
               r.token_kind = KIND_PFX;
               r.is_content = 1'b1;
            end
         end
         ST_PREFIX_GAP: begin
            // a colon here is plain command text
            if (!sp) begin
               r.token_kind  = KIND_CMD;
               r.token_start = 1'b1;
               r.is_content  = 1'b1;
               line_phase    = ST_COMMAND;
            end
         end
         ST_COMMAND: begin
            if (sp) begin
               line_phase = ST_PARAM_GAP;
            end else begin
               r.token_kind = KIND_CMD;
               r.is_content = 1'b1;
            end
         end
         ST_PARAM_GAP: begin
            if (!sp) begin
               if (open_params >= limit_params)
                  note_error(ERR_MANY);
               r.param_number = open_params;
               if (open_params < PCNT_MAX)
                  open_params = open_params + 1'b1;
               r.token_start = 1'b1;
               if (b == CHAR_COLON) begin
                  r.token_kind = KIND_TRAIL;
                  line_phase   = ST_TRAILING;
               end else begin
                  r.token_kind = KIND_PARAM;
                  r.is_content = 1'b1;
                  line_phase   = ST_MIDDLE;
               end
            end
         end
         ST_MIDDLE: begin
            if (sp) begin
               line_phase = ST_PARAM_GAP;
            end else begin
               r.token_kind   = KIND_PARAM;
               r.is_content   = 1'b1;
               r.param_number = (open_params != 0) ? open_params - 1'b1 : '0;
            end
         end
         default: begin
            // trailing text keeps spaces and colons
            r.token_kind   = KIND_TRAIL;
            r.is_content   = 1'b1;
            r.param_number = (open_params != 0) ? open_params - 1'b1 : '0;
         end
      endcase
      if (r.token_kind == KIND_CMD && b >= 8'h61 && b <= 8'h7A)
         r.byte_out = b - CASE_DELTA;
      r.line_done = last;
      if (last) begin
         if (line_phase == ST_MARK)
            note_error(ERR_PFX);
         else if (line_phase == ST_LEAD || line_phase == ST_PREFIX ||
                  line_phase == ST_PREFIX_GAP)
            note_error(ERR_CMD);
         r.line_ok    = (first_fault == ERR_NONE);
         r.error_code = first_fault;
         line_phase   = ST_LEAD;
         open_params  = '0;
         first_fault  = ERR_NONE;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------

   task automatic add_row(input logic [BYTE_W-1:0] b, input logic last,
                          input bit typed, input result_type want);
      stim_row_type row;
      row.b     = b;
      row.last  = last;
      row.typed = typed;
      row.want  = want;
      directed.insert(directed.size(), row);
   endtask

   // One byte transfer; the expectation is queued at the accepting edge.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                            input bit typed, input result_type want);
      result_type  predicted;
      int unsigned gap;
      int unsigned pick;
      gap = 0;
      if (!req_quiet) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            gap = 0;
         else if (pick < 90)
            gap = $urandom_range(1, 3);
         else if (pick < 98)
            gap = $urandom_range(4, 12);
         else
            gap = $urandom_range(20, 60);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_line_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = tag_byte(b, last);
      expected_tags.insert(expected_tags.size(), typed ? want : predicted);
      bytes_sent++;
   endtask

   // Sender stops until every queued result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] word_char();
      int unsigned pick;
      pick = $urandom_range(0, 3);
      if (pick < 2)
         return 8'($urandom_range(8'h61, 8'h7A));   // lowercase, uppercased in command
      else if (pick == 2)
         return 8'($urandom_range(8'h41, 8'h5A));
      else
         return 8'($urandom_range(8'h21, 8'hFF));   // never space or NUL
   endfunction

   // Mostly well-formed lines with random content, some raw noise.
   task automatic send_random_line();
      logic [BYTE_W-1:0] text[$];
      int unsigned       style;
      int unsigned       n_params;
      int unsigned       len;
      int unsigned       i;
      int unsigned       j;
      style = $urandom_range(0, 99);
      if (style < 12) begin
         len = $urandom_range(1, 8);
         for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 5))
               0:       text.insert(text.size(), CHAR_SPACE);
               1:       text.insert(text.size(), CHAR_COLON);
               default: text.insert(text.size(), 8'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) text.insert(text.size(), CHAR_SPACE);
         if ($urandom_range(0, 9) < 4) begin
            text.insert(text.size(), CHAR_COLON);
            // zero characters give an empty prefix
            repeat ($urandom_range(0, 5)) text.insert(text.size(), word_char());
            if ($urandom_range(0, 9) != 0)
               repeat ($urandom_range(1, 2)) text.insert(text.size(), CHAR_SPACE);
         end
         if ($urandom_range(0, 19) != 0) begin
            repeat ($urandom_range(1, 6)) text.insert(text.size(), word_char());
            case ($urandom_range(0, 19))
               0, 1, 2:  n_params = $urandom_range(14, 18);  // drives the counter to saturation
               3, 4, 5, 6, 7, 8, 9:
                         n_params = $urandom_range(0, limit_params + 1);
               default:  n_params = $urandom_range(0, 3);
            endcase
            for (i = 0; i < n_params; i++) begin
               repeat ($urandom_range(1, 2)) text.insert(text.size(), CHAR_SPACE);
               if (i + 1 == n_params && $urandom_range(0, 9) < 3) begin
                  text.insert(text.size(), CHAR_COLON);
                  len = $urandom_range(0, 6);
                  for (j = 0; j < len; j++) begin
                     case ($urandom_range(0, 4))
                        0:       text.insert(text.size(), CHAR_SPACE);
                        1:       text.insert(text.size(), CHAR_COLON);
                        default: text.insert(text.size(), 8'($urandom_range(1, 255)));
                     endcase
                  end
               end else begin
                  repeat ($urandom_range(1, 5)) text.insert(text.size(), word_char());
               end
            end
            if ($urandom_range(0, 9) == 0)
               text.insert(text.size(), CHAR_SPACE);
         end
         if (text.size() == 0)
            text.insert(text.size(), CHAR_SPACE);
         if ($urandom_range(0, 99) < 6)
            text[$urandom_range(0, text.size() - 1)] = CHAR_NUL;
      end
      for (i = 0; i < text.size(); i++)
         send_byte(text[i], (i + 1 == text.size()), 1'b0, '0);
   endtask

   // Write the parameter limit over APB, then read it back.
   task automatic write_param_limit(input logic [PCNT_W-1:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_PARAM_LIMIT;
      pwdata  <= {{(32-PCNT_W){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // write lands at this edge; set up the read-back
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {{(32-PCNT_W){1'b0}}, value}) begin
         $display("%0t: param limit read-back expected %0h, got %0h", $time, value, prdata);
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      limit_params = value;
   endtask

   // ------------------------------------------------------------------
   // Receiver side
   // ------------------------------------------------------------------

   // Stall runs: mostly short, now and then a long one.
   initial begin
      int unsigned hold;
      int unsigned pick;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold != 0) begin
            hold--;
         end else if (rsp_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               rsp_stall <= 1'b0;
               hold = $urandom_range(0, 4);
            end else if (pick < 95) begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(0, 3);
            end else begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(10, 40);
            end
         end
      end
   end

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   // Each result transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_tags.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, got byte %0h",
                     $time, rsp_byte_out);
            fail_count++;
         end else begin
            want = expected_tags.pop_front();
            compare_field("byte_out", want.byte_out, rsp_byte_out);
            compare_field("token_kind", 8'(want.token_kind), 8'(rsp_token_kind));
            compare_field("token_start", 8'(want.token_start), 8'(rsp_token_start));
            compare_field("is_content", 8'(want.is_content), 8'(rsp_is_content));
            compare_field("param_number", 8'(want.param_number), 8'(rsp_param_number));
            compare_field("line_done", 8'(want.line_done), 8'(rsp_line_done));
            compare_field("line_ok", 8'(want.line_ok), 8'(rsp_line_ok));
            compare_field("error_code", 8'(want.error_code), 8'(rsp_error_code));
         end
      end
   end

   // Watchdog: too long without any transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("irc_line_tokenizer test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned       phase_bytes;
      int unsigned       sent_mark;
      int unsigned       k;
      bit                paused;
      logic [PCNT_W-1:0] setting;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_line_byte = '0;
      req_last_byte = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      fail_count    = 0;
      bytes_sent    = 0;
      req_quiet     = 1'b0;
      rsp_quiet     = 1'b0;
      line_phase    = ST_LEAD;
      open_params   = '0;
      first_fault   = ERR_NONE;
      limit_params  = PARAM_LIMIT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed lines, register at its reset value.
      // lone colon: empty prefix
      add_row(CHAR_COLON, 1'b1, 1'b1,
              make_tags(CHAR_COLON, KIND_PFX, 1'b1, 1'b0, 4'd0, 1'b1, 1'b0, ERR_PFX));
      // lone space: no command at all
      add_row(CHAR_SPACE, 1'b1, 1'b1,
              make_tags(CHAR_SPACE, KIND_SEP, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, ERR_CMD));
      // lowest and highest byte as one-byte commands
      add_row(8'h00, 1'b1, 1'b1,
              make_tags(8'h00, KIND_CMD, 1'b1, 1'b1, 4'd0, 1'b1, 1'b0, ERR_NUL));
      add_row(8'hFF, 1'b1, 1'b1,
              make_tags(8'hFF, KIND_CMD, 1'b1, 1'b1, 4'd0, 1'b1, 1'b1, ERR_NONE));
      // ":n :z p : :" - colon after the prefix is command text, trailing keeps ' ' and ':'
      add_row(CHAR_COLON, 1'b0, 1'b0, '0);
      add_row("n",        1'b0, 1'b0, '0);
      add_row(CHAR_SPACE, 1'b0, 1'b0, '0);
      add_row(CHAR_COLON, 1'b0, 1'b0, '0);
      add_row("z",        1'b0, 1'b0, '0);
      add_row(CHAR_SPACE, 1'b0, 1'b0, '0);
      add_row("p",        1'b0, 1'b0, '0);
      add_row(CHAR_SPACE, 1'b0, 1'b0, '0);
      add_row(CHAR_COLON, 1'b0, 1'b0, '0);
      add_row(CHAR_SPACE, 1'b0, 1'b0, '0);
      add_row(CHAR_COLON, 1'b1, 1'b0, '0);
      // ": a<NUL>" - empty prefix, tagging goes on, NUL overrides the code
      add_row(CHAR_COLON, 1'b0, 1'b0, '0);
      add_row(CHAR_SPACE, 1'b0, 1'b0, '0);
      add_row("a",        1'b0, 1'b0, '0);
      add_row(CHAR_NUL,   1'b1, 1'b1,
              make_tags(CHAR_NUL, KIND_CMD, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0, ERR_NUL));
      // "a :" - colon alone opens an empty trailing parameter
      add_row("a",        1'b0, 1'b0, '0);
      add_row(CHAR_SPACE, 1'b0, 1'b0, '0);
      add_row(CHAR_COLON, 1'b1, 1'b1,
              make_tags(CHAR_COLON, KIND_TRAIL, 1'b1, 1'b0, 4'd0, 1'b1, 1'b1, ERR_NONE));
      foreach (directed[i])
         send_byte(directed[i].b, directed[i].last, directed[i].typed, directed[i].want);
      drain_results();

      // Random lines under several settings, zero and both extremes among them.
      for (k = 0; k < 6; k++) begin
         case (k)
            0:       setting = 4'd1;
            1:       setting = 4'd0;
            2:       setting = 4'd15;
            3:       setting = 4'd7;
            4:       setting = 4'($urandom_range(1, 14));
            default: setting = 4'd2;
         endcase
         write_param_limit(setting);
         phase_bytes = 0;
         paused      = 1'b0;
         while (phase_bytes < PHASE_BYTES) begin
            req_quiet = ($urandom_range(0, 5) == 0);
            rsp_quiet = ($urandom_range(0, 5) == 0);
            sent_mark = bytes_sent;
            send_random_line();
            phase_bytes += bytes_sent - sent_mark;
            // mid-phase hold-off until the result queue runs dry
            if (!paused && phase_bytes > PHASE_BYTES / 2) begin
               drain_results();
               paused = 1'b1;
            end
         end
         drain_results();
      end

      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("irc_line_tokenizer test passed");
      else
         $display("irc_line_tokenizer test failed");
      $finish;
   end

endmodule
